// ===== sv/ipa_pkg.sv =====
// ----------------------------------------------------------------------------
// ipa_pkg: index primitive assembly shared types
// Topology codes, register indexes and the request/result payload structs.
// ----------------------------------------------------------------------------
package ipa_pkg;

	// input topology codes, codes above the last adjacency form emit nothing
	typedef enum logic [3:0] {
		TOPO_POINTS        = 4'd0,
		TOPO_LINES         = 4'd1,
		TOPO_LINE_STRIP    = 4'd2,
		TOPO_LINE_LOOP     = 4'd3,
		TOPO_TRIS          = 4'd4,
		TOPO_TRI_STRIP     = 4'd5,
		TOPO_FAN           = 4'd6,
		TOPO_LINES_ADJ     = 4'd7,
		TOPO_LINE_STRIP_AD = 4'd8,
		TOPO_TRIS_ADJ      = 4'd9,
		TOPO_TRI_STRIP_ADJ = 4'd10
	} ipa_topo_t;

	// configuration register indexes
	localparam logic [1:0] CFG_TOPOLOGY   = 2'd0;
	localparam logic [1:0] CFG_RESTART_EN = 2'd1;
	localparam logic [1:0] CFG_RESTART_VL = 2'd2;
	localparam logic [1:0] CFG_INSTANCE   = 2'd3;

	localparam int WIN_DEPTH = 10;

	typedef struct packed {
		ipa_topo_t   input_topology;
		logic        restart_enable;
		logic [31:0] restart_value;
		logic [31:0] instance_number;
	} ipa_cfg_t;

	typedef struct packed {
		logic [31:0] index_value;
		logic        last_of_draw;
	} ipa_in_t;

	typedef struct packed {
		logic [31:0] vertex_a;
		logic [31:0] vertex_b;
		logic [31:0] vertex_c;
		logic [31:0] vertex_d;
		logic [31:0] vertex_e;
		logic [31:0] vertex_f;
		logic [2:0]  vertices_used;
		logic [31:0] primitive_number;
		logic [31:0] instance_out;
		logic        last_of_run;
	} ipa_out_t;

	// up to two results produced by one request
	typedef struct packed {
		logic [1:0] count;
		ipa_out_t   r0;
		ipa_out_t   r1;
	} ipa_res_t;

endpackage

// ===== sv/ipa_assemble.sv =====
// ----------------------------------------------------------------------------
// ipa_assemble: segment state and primitive selection
// Holds the index window and segment counters, and builds the step primitive
// and the segment-end primitive for the request in the input register.
// ----------------------------------------------------------------------------
module ipa_assemble import ipa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ipa_cfg_t cfg,
	input  ipa_in_t  item,
	input  logic     fire,
	output ipa_res_t res
);

	typedef logic [5:0][31:0] vset_t;

	logic [WIN_DEPTH-1:0][31:0] win_q;
	logic [31:0] first_q;
	logic [31:0] second_q;
	logic [31:0] pos_q;
	logic [2:0]  mod6_q;
	logic [31:0] pc_q;

	logic [WIN_DEPTH-1:0][31:0] nw;
	logic [WIN_DEPTH-1:0][31:0] ew;
	logic        restart;
	logic [31:0] p;
	logic [31:0] p_inc;
	logic [31:0] first_n;
	logic [31:0] second_n;
	logic        s_v;
	vset_t       s_vt;
	logic [2:0]  s_used;
	logic        e_v;
	vset_t       e_vt;
	logic [2:0]  e_used;
	logic [31:0] ecnt;
	logic        e_en;
	logic        e_even;
	logic [1:0]  e_ilo;
	logic [1:0]  s_ilo;
	logic [31:0] e_ab;
	logic [1:0]  cnt;

	// strip adjacency ordering, odd pairs rotate the triangle
	function automatic vset_t strip_prim(input logic [31:0] vi, input logic [31:0] v2,
		input logic [31:0] v3, input logic [31:0] v4, input logic [31:0] bc,
		input logic [31:0] ab, input logic par);
		vset_t v;
		if (par) begin
			v = {bc, v4, v3, vi, ab, v2};
		end else begin
			v = {v3, v4, bc, v2, ab, vi};
		end
		return v;
	endfunction

	function automatic ipa_out_t pack_out(input vset_t v, input logic [2:0] used,
		input logic [31:0] num, input logic [31:0] inst, input logic lst);
		ipa_out_t o;
		o.vertex_a         = v[0];
		o.vertex_b         = v[1];
		o.vertex_c         = v[2];
		o.vertex_d         = v[3];
		o.vertex_e         = v[4];
		o.vertex_f         = v[5];
		o.vertices_used    = used;
		o.primitive_number = num;
		o.instance_out     = inst;
		o.last_of_run      = lst;
		return o;
	endfunction

	// window after shifting in the new index, segment position tracking
	always_comb begin
		restart = cfg.restart_enable && (item.index_value == cfg.restart_value);
		p       = pos_q;
		p_inc   = pos_q + 32'd1;
		nw[0]   = item.index_value;
		for (int k = 1; k < WIN_DEPTH; k++) begin
			nw[k] = win_q[k-1];
		end
		first_n  = (!restart && p == 32'd0) ? item.index_value : first_q;
		second_n = (!restart && p == 32'd1) ? item.index_value : second_q;
	end

	// primitive completed by the incoming index
	always_comb begin
		s_v    = 1'b0;
		s_vt   = '0;
		s_used = 3'd0;
		s_ilo  = p[1:0] - 2'd3;
		if (!restart) begin
			case (cfg.input_topology)
				TOPO_POINTS: begin
					s_v    = 1'b1;
					s_vt   = {96'd0, 32'd0, 32'd0, nw[0]};
					s_used = 3'd1;
				end
				TOPO_LINES: begin
					s_v    = p[0];
					s_vt   = {96'd0, 32'd0, nw[0], nw[1]};
					s_used = 3'd2;
				end
				TOPO_LINE_STRIP, TOPO_LINE_LOOP: begin
					s_v    = (p != 32'd0);
					s_vt   = {96'd0, 32'd0, nw[0], nw[1]};
					s_used = 3'd2;
				end
				TOPO_TRIS: begin
					s_v    = (mod6_q == 3'd2) || (mod6_q == 3'd5);
					s_vt   = {96'd0, nw[0], nw[1], nw[2]};
					s_used = 3'd3;
				end
				TOPO_TRI_STRIP: begin
					s_v    = (p >= 32'd2);
					s_vt   = p[0] ? {96'd0, nw[0], nw[2], nw[1]}
						: {96'd0, nw[0], nw[1], nw[2]};
					s_used = 3'd3;
				end
				TOPO_FAN: begin
					s_v    = (p >= 32'd2);
					s_vt   = {96'd0, nw[0], nw[1], first_n};
					s_used = 3'd3;
				end
				TOPO_LINES_ADJ: begin
					s_v    = (p[1:0] == 2'd3);
					s_vt   = {64'd0, nw[0], nw[1], nw[2], nw[3]};
					s_used = 3'd4;
				end
				TOPO_LINE_STRIP_AD: begin
					s_v    = (p >= 32'd3);
					s_vt   = {64'd0, nw[0], nw[1], nw[2], nw[3]};
					s_used = 3'd4;
				end
				TOPO_TRIS_ADJ: begin
					s_v    = (mod6_q == 3'd5);
					s_vt   = {nw[0], nw[1], nw[2], nw[3], nw[4], nw[5]};
					s_used = 3'd6;
				end
				TOPO_TRI_STRIP_ADJ: begin
					s_v    = (p >= 32'd7) && p[0];
					s_vt   = strip_prim(nw[7], nw[5], nw[4], nw[3], nw[1],
						(p == 32'd7) ? second_n : nw[9], s_ilo[1]);
					s_used = 3'd6;
				end
				default: begin
					s_v = 1'b0;
				end
			endcase
		end
	end

	// segment end: restart uses the unshifted window, last of draw the shifted one
	always_comb begin
		ew     = restart ? win_q : nw;
		ecnt   = restart ? p : p_inc;
		e_en   = restart ? (p != 32'd0) : item.last_of_draw;
		e_even = !ecnt[0];
		e_ilo  = e_even ? (ecnt[1:0] - 2'd2) : (ecnt[1:0] - 2'd3);
		e_ab   = ((ecnt == 32'd6) || (ecnt == 32'd7)) ? second_n
			: (e_even ? ew[7] : ew[8]);
		e_v    = 1'b0;
		e_vt   = '0;
		e_used = 3'd0;
		if (cfg.input_topology == TOPO_LINE_LOOP) begin
			e_v    = e_en && (ecnt >= 32'd2);
			e_vt   = {96'd0, 32'd0, first_n, ew[0]};
			e_used = 3'd2;
		end else if (cfg.input_topology == TOPO_TRI_STRIP_ADJ) begin
			e_v    = e_en && (ecnt >= 32'd6);
			e_vt   = strip_prim(e_even ? ew[5] : ew[6], e_even ? ew[3] : ew[4],
				e_even ? ew[2] : ew[3], e_even ? ew[1] : ew[2],
				e_even ? ew[0] : ew[1], e_ab, e_ilo[1]);
			e_used = 3'd6;
		end
	end

	// result assembly, step primitive goes first
	always_comb begin
		cnt       = {1'b0, s_v} + {1'b0, e_v};
		res.count = cnt;
		res.r0    = pack_out(s_v ? s_vt : e_vt, s_v ? s_used : e_used, pc_q,
			cfg.instance_number, !(s_v && e_v));
		res.r1    = pack_out(e_vt, e_used, pc_q + 32'd1, cfg.instance_number, 1'b1);
	end

	// state update when the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			pos_q    <= '0;
			mod6_q   <= '0;
			pc_q     <= '0;
		end else if (fire) begin
			if (!restart) begin
				win_q    <= nw;
				first_q  <= first_n;
				second_q <= second_n;
			end
			if (restart || item.last_of_draw) begin
				pos_q  <= '0;
				mod6_q <= '0;
			end else begin
				pos_q <= p_inc;
				// position wraps to zero at the counter limit, keep residue aligned
				if (p == 32'hFFFF_FFFF || mod6_q == 3'd5) begin
					mod6_q <= 3'd0;
				end else begin
					mod6_q <= mod6_q + 3'd1;
				end
			end
			if (item.last_of_draw) begin
				pc_q <= '0;
			end else begin
				pc_q <= pc_q + {30'd0, cnt};
			end
		end
	end

endmodule

// ===== sv/ipa_out_buf.sv =====
// ----------------------------------------------------------------------------
// ipa_out_buf: two-slot result buffer
// Takes up to two results at once and presents them one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ipa_out_buf import ipa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ipa_res_t res,
	input  logic     load,
	output logic     load_ok,
	output logic     out_valid,
	input  logic     out_ready,
	output ipa_out_t out_data
);

	logic     slot0_v_q;
	logic     slot1_v_q;
	ipa_out_t slot0_q;
	ipa_out_t slot1_q;

	// room only when the buffer drains empty this cycle
	assign load_ok   = !slot1_v_q && (!slot0_v_q || out_ready);
	assign out_valid = slot0_v_q;
	assign out_data  = slot0_q;

	// slot control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_v_q <= 1'b0;
			slot1_v_q <= 1'b0;
		end else if (load) begin
			slot0_v_q <= (res.count != 2'd0);
			slot1_v_q <= (res.count == 2'd2);
		end else if (slot0_v_q && out_ready) begin
			slot0_v_q <= slot1_v_q;
			slot1_v_q <= 1'b0;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res.r0;
			slot1_q <= res.r1;
		end else if (slot0_v_q && out_ready) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ===== sv/index_primitive_assembly_top.sv =====
// ----------------------------------------------------------------------------
// index_primitive_assembly_top: indexed primitive assembly with restart
// Assembles vertex indices into primitives for eleven input topologies.
//
//   channel  signals                          direction  moves
//   in       in_valid/in_ready/in_data        in         one vertex index
//   out      out_valid/out_ready/out_data     out        one primitive
//   cfg      cfg_valid/cfg_ready/cfg_index/   in         one register write
//            cfg_data
//
// A request is registered, assembled in one pass and written into a
// two-slot result buffer, so one index is taken every cycle while each
// index yields at most one primitive and out_ready stays high. An index
// yielding two primitives (segment end on line loop or strip adjacency)
// holds the input while the buffer drains. Reset clears the window, counters
// and configuration; the input register waits while the buffer is not free.
// ----------------------------------------------------------------------------
module index_primitive_assembly_top import ipa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ipa_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ipa_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ipa_cfg_t cfg_q;
	ipa_in_t  item_s1;
	logic     item_v_s1;
	logic     load_ok;
	logic     fire;
	ipa_res_t res;

	assign cfg_ready = 1'b1;
	assign fire      = item_v_s1 && load_ok;
	assign in_ready  = !item_v_s1 || load_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_topology  <= TOPO_POINTS;
			cfg_q.restart_enable  <= 1'b0;
			cfg_q.restart_value   <= 32'hFFFF_FFFF;
			cfg_q.instance_number <= 32'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOPOLOGY:   cfg_q.input_topology  <= ipa_topo_t'(cfg_data[3:0]);
				CFG_RESTART_EN: cfg_q.restart_enable  <= cfg_data[0];
				CFG_RESTART_VL: cfg_q.restart_value   <= cfg_data;
				CFG_INSTANCE:   cfg_q.instance_number <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			item_v_s1 <= 1'b1;
		end else if (fire) begin
			item_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	ipa_assemble u_assemble (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.fire   (fire),
		.res    (res)
	);

	ipa_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.load      (fire),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// any assembled primitive shows up on the output next cycle
	a_res_shown: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.count != 2'd0 |=> out_valid)
		else $error("assembled primitive not presented");

	// a pair of results presents the non-final one first
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.count == 2'd2 |=> out_valid && !out_data.last_of_run)
		else $error("first of two results marked final");

	// a held request stays in the input register
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_v_s1 && !load_ok |=> item_v_s1)
		else $error("request dropped while buffer busy");

	// only legal slot counts leave the block
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.vertices_used == 3'd1 || out_data.vertices_used == 3'd2
			|| out_data.vertices_used == 3'd3 || out_data.vertices_used == 3'd4
			|| out_data.vertices_used == 3'd6))
		else $error("bad vertex slot count");

endmodule

// ===== bench/ipa_prim_checker.sv =====
// ----------------------------------------------------------------------------
// ipa_prim_checker: primitive assembly scoreboard
// Watches the request, result and register-write channels of the block,
// keeps its own window, segment and draw state, predicts the primitives
// each accepted index produces and compares every accepted primitive
// field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module ipa_prim_checker import ipa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  ipa_in_t     in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  ipa_out_t    out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);

	// shadow of the configuration registers
	logic [3:0]  topo;
	logic        restart_on;
	logic [31:0] restart_idx;
	logic [31:0] inst_num;

	// assembly state: newest index at slot 0
	logic [31:0] win [WIN_DEPTH];
	logic [31:0] seg_first;
	logic [31:0] seg_second;
	logic [31:0] seg_pos;
	logic [31:0] prim_num;

	// primitives made by the current request, then the ones still owed
	ipa_out_t    step_prims [2];
	int          step_cnt;
	ipa_out_t    primitives_due [$];
	ipa_out_t    want;
	int          err_cnt;

	// window lookup by segment position, zero past the window
	function automatic logic [31:0] win_at(input logic [31:0] pos,
			input logic [31:0] newest);
		logic [31:0] k;
		k = newest - pos;
		return (k < WIN_DEPTH) ? win[k] : 32'd0;
	endfunction

	function automatic void emit(input logic [31:0] va, input logic [31:0] vb,
			input logic [31:0] vc, input logic [31:0] vd, input logic [31:0] ve,
			input logic [31:0] vf, input logic [2:0] used);
		if (step_cnt < 2) begin
			step_prims[step_cnt] = {va, vb, vc, vd, ve, vf, used, prim_num,
				inst_num, 1'b0};
			step_cnt++;
			prim_num = prim_num + 32'd1;
		end
	endfunction

	// strip adjacency triangle starting at segment position i
	function automatic void strip_adj(input logic [31:0] i,
			input logic [31:0] bc_pos, input logic [31:0] newest);
		logic [31:0] ab, bc, ca;
		ab = (i == 32'd0) ? seg_second : win_at(i - 32'd2, newest);
		bc = win_at(bc_pos, newest);
		ca = win_at(i + 32'd3, newest);
		if (i[1])
			emit(win_at(i + 32'd2, newest), ab, win_at(i, newest), ca,
				win_at(i + 32'd4, newest), bc, 3'd6);
		else
			emit(win_at(i, newest), ab, win_at(i + 32'd2, newest), bc,
				win_at(i + 32'd4, newest), ca, 3'd6);
	endfunction

	// segment end: close the loop or flush the pending strip adjacency triangle
	function automatic void close_segment(input logic [31:0] count);
		logic [31:0] i;
		if (topo == TOPO_LINE_LOOP && count >= 32'd2)
			emit(win[0], seg_first, 32'd0, 32'd0, 32'd0, 32'd0, 3'd2);
		if (topo == TOPO_TRI_STRIP_ADJ && count >= 32'd6) begin
			i = count[0] ? count - 32'd7 : count - 32'd6;
			strip_adj(i, i + 32'd5, count - 32'd1);
		end
	endfunction

	// one accepted index: update state and queue the primitives it yields
	function automatic void assemble_index(input logic [31:0] idx, input logic last);
		logic [31:0] p;
		int          k;
		step_cnt = 0;
		if (restart_on && idx == restart_idx) begin
			if (seg_pos != 32'd0)
				close_segment(seg_pos);
			seg_pos = 32'd0;
		end else begin
			for (k = WIN_DEPTH - 1; k > 0; k--)
				win[k] = win[k - 1];
			win[0] = idx;
			p = seg_pos;
			if (p == 32'd0)
				seg_first = idx;
			if (p == 32'd1)
				seg_second = idx;
			seg_pos = p + 32'd1;
			case (topo)
				TOPO_POINTS: begin
					emit(idx, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd1);
				end
				TOPO_LINES: begin
					if (p[0])
						emit(win[1], idx, 32'd0, 32'd0, 32'd0, 32'd0, 3'd2);
				end
				TOPO_LINE_STRIP, TOPO_LINE_LOOP: begin
					if (p >= 32'd1)
						emit(win[1], idx, 32'd0, 32'd0, 32'd0, 32'd0, 3'd2);
				end
				TOPO_TRIS: begin
					if (p % 32'd3 == 32'd2)
						emit(win[2], win[1], idx, 32'd0, 32'd0, 32'd0, 3'd3);
				end
				TOPO_TRI_STRIP: begin
					// odd triangles swap their first two vertices
					if (p >= 32'd2) begin
						if (p[0])
							emit(win[1], win[2], idx, 32'd0, 32'd0, 32'd0, 3'd3);
						else
							emit(win[2], win[1], idx, 32'd0, 32'd0, 32'd0, 3'd3);
					end
				end
				TOPO_FAN: begin
					if (p >= 32'd2)
						emit(seg_first, win[1], idx, 32'd0, 32'd0, 32'd0, 3'd3);
				end
				TOPO_LINES_ADJ: begin
					if (p[1:0] == 2'b11)
						emit(win[3], win[2], win[1], idx, 32'd0, 32'd0, 3'd4);
				end
				TOPO_LINE_STRIP_AD: begin
					if (p >= 32'd3)
						emit(win[3], win[2], win[1], idx, 32'd0, 32'd0, 3'd4);
				end
				TOPO_TRIS_ADJ: begin
					if (p % 32'd6 == 32'd5)
						emit(win[5], win[4], win[3], win[2], win[1], win[0], 3'd6);
				end
				TOPO_TRI_STRIP_ADJ: begin
					if (p >= 32'd7 && p[0])
						strip_adj(p - 32'd7, p - 32'd1, p);
				end
				default: begin
				end
			endcase
			if (last) begin
				close_segment(seg_pos);
				seg_pos = 32'd0;
			end
		end
		if (last) begin
			seg_pos  = 32'd0;
			prim_num = 32'd0;
		end
		for (k = 0; k < step_cnt; k++) begin
			if (k == step_cnt - 1)
				step_prims[k].last_of_run = 1'b1;
			primitives_due.push_back(step_prims[k]);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			err_cnt++;
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
		end
	endfunction

	// sample all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topo        = TOPO_POINTS;
			restart_on  = 1'b0;
			restart_idx = '1;
			inst_num    = '0;
			foreach (win[k])
				win[k] = '0;
			seg_first   = '0;
			seg_second  = '0;
			seg_pos     = '0;
			prim_num    = '0;
			primitives_due.delete();
			err_cnt     = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// predict first so a same-cycle result still finds its entry
			if (in_valid && in_ready)
				assemble_index(in_data.index_value, in_data.last_of_draw);

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TOPOLOGY:   topo        = cfg_data[3:0];
					CFG_RESTART_EN: restart_on  = cfg_data[0];
					CFG_RESTART_VL: restart_idx = cfg_data;
					CFG_INSTANCE:   inst_num    = cfg_data;
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (primitives_due.size() == 0) begin
					err_cnt++;
					$error("primitive with none due: vertex_a %0h number %0h",
						out_data.vertex_a, out_data.primitive_number);
				end else begin
					want = primitives_due.pop_front();
					check_field("vertex_a", want.vertex_a, out_data.vertex_a);
					check_field("vertex_b", want.vertex_b, out_data.vertex_b);
					check_field("vertex_c", want.vertex_c, out_data.vertex_c);
					check_field("vertex_d", want.vertex_d, out_data.vertex_d);
					check_field("vertex_e", want.vertex_e, out_data.vertex_e);
					check_field("vertex_f", want.vertex_f, out_data.vertex_f);
					check_field("vertices_used", 32'(want.vertices_used),
						32'(out_data.vertices_used));
					check_field("primitive_number", want.primitive_number,
						out_data.primitive_number);
					check_field("instance_out", want.instance_out, out_data.instance_out);
					check_field("last_of_run", 32'(want.last_of_run),
						32'(out_data.last_of_run));
				end
			end

			errors  <= err_cnt;
			pending <= primitives_due.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: index primitive assembly testbench
// Drives index requests and register writes into the block with random
// gaps and result backpressure, first a directed set of corner sequences,
// then random draws under every topology; the checker scores each result.
// ----------------------------------------------------------------------------
module tb import ipa_pkg::*; ();

	localparam int STALL_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_ITEMS   = 750;
	localparam int TOPO_CODE_MAX  = 15;
	localparam int TOPO_KNOWN_CNT = 11;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	ipa_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	ipa_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int          errors;
	int          pending;
	int          quiet_cycles = 0;
	bit          send_gaps;
	logic [31:0] cur_restart;

	index_primitive_assembly_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ipa_prim_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap(input bit allowed);
		int r;
		if (!allowed)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// index values: restart marker, extremes, small repeats, full range
	function automatic logic [31:0] pick_index();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return cur_restart;
		if (r < 14)
			return '1;
		if (r < 18)
			return '0;
		if (r < 40)
			return 32'($urandom_range(15));
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(3))
			0: return '1;
			1: return '0;
			2: return 32'($urandom_range(15));
			default: return $urandom();
		endcase
	endfunction

	// one index request, held until accepted
	task automatic push_index(input logic [31:0] idx, input logic last);
		int gap;
		gap = pick_gap(send_gaps);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {idx, last};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [3:0] topo, input logic restart_on,
			input logic [31:0] restart_idx, input logic [31:0] inst_num);
		write_reg(CFG_TOPOLOGY, 32'(topo));
		write_reg(CFG_RESTART_EN, 32'(restart_on));
		write_reg(CFG_RESTART_VL, restart_idx);
		write_reg(CFG_INSTANCE, inst_num);
		cfg_valid   <= 1'b0;
		cur_restart  = restart_idx;
	endtask

	// stop sending, wait for every owed primitive, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// draws of random length ending in last, with stray last flags as noise
	task automatic run_draws(input int n_items);
		int left, draw_len, j;
		logic last;
		left = n_items;
		while (left > 0) begin
			draw_len = ($urandom_range(9) == 0) ? $urandom_range(40, 20)
				: $urandom_range(12, 1);
			for (j = 0; j < draw_len && left > 0; j++) begin
				last = (j == draw_len - 1) || ($urandom_range(49) == 0);
				push_index(pick_index(), last);
				left--;
			end
		end
	endtask

	// result side backpressure: bursts of ready, some very long, then stalls
	initial begin : result_side
		int burst, stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			burst = ($urandom_range(9) == 0) ? $urandom_range(300, 100)
				: $urandom_range(20, 1);
			stall = pick_gap(1'b1);
			out_ready <= 1'b1;
			repeat (burst) @(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int sent, phase, n, j;
		logic [3:0] topo;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_TOPOLOGY;
		cfg_data    <= '0;
		send_gaps    = 1'b1;
		cur_restart  = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// points with extreme indices, restart value matches but restart is off
		configure(TOPO_POINTS, 1'b0, '1, '1);
		push_index('0, 1'b0);
		push_index('1, 1'b0);
		push_index('1, 1'b1);
		settle();

		// unknown topology: restart on an empty segment, restart with last
		topo = 4'($urandom_range(TOPO_CODE_MAX, int'(TOPO_TRI_STRIP_ADJ) + 1));
		configure(topo, 1'b1, '0, '0);
		push_index('0, 1'b0);
		push_index(32'd7, 1'b0);
		push_index('0, 1'b1);
		settle();

		// line loop closed by restart, by last, and by restart with last
		configure(TOPO_LINE_LOOP, 1'b1, 32'h0000_1234, 32'h5a5a_a5a5);
		push_index(32'd5, 1'b0);
		push_index(32'd6, 1'b0);
		push_index(32'd7, 1'b0);
		push_index(32'h0000_1234, 1'b0);
		push_index(32'd8, 1'b0);
		push_index(32'd9, 1'b1);
		push_index(32'd3, 1'b0);
		push_index(32'd4, 1'b0);
		push_index(32'h0000_1234, 1'b1);
		settle();

		// strip adjacency with the lookahead triangle flushed at the end
		configure(TOPO_TRI_STRIP_ADJ, 1'b0, 32'h0000_1234, 32'hffff_0000);
		for (j = 1; j <= 9; j++)
			push_index(32'(j), j == 9);
		settle();

		// random phases cycling through all topologies plus unknown codes;
		// a phase may stop mid-draw so the next topology picks up the segment
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase % (TOPO_KNOWN_CNT + 1) == TOPO_KNOWN_CNT)
				topo = 4'($urandom_range(TOPO_CODE_MAX, TOPO_KNOWN_CNT));
			else
				topo = 4'(phase % (TOPO_KNOWN_CNT + 1));
			configure(topo, $urandom_range(3) != 0, pick_word(), pick_word());
			send_gaps = ($urandom_range(3) != 0);
			n = $urandom_range(60, 15);
			run_draws(n);
			settle();
			sent += n;
			phase++;
		end

		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
